// File: hdl/ttcw_pkg.sv
// ttcw_pkg: shared types and constants for the text terminal character writer
// no dependencies; used by every file of the block but ttcw_ram
package ttcw_pkg;

    localparam int CHAR_W      = 8;
    localparam int POS_W       = 11;
    localparam int FUNC_W      = 2;
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  cell_index;
    } cmd_word_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CHAR_W-1:0] cell_char;
    } result_word_t;

    typedef struct packed {
        logic update;
        logic clear;
    } cursor_ctl_t;

    typedef struct packed {
        logic              scroll;
        logic              wr_en;
        logic [CHAR_W-1:0] wr_data;
    } put_plan_t;

endpackage

// File: hdl/ttcw_ram.sv
// ttcw_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
module ttcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ttcw_cursor.sv
// ttcw_cursor: cursor column, row and row base registers, and the put-character plan
// depends on ttcw_pkg
module ttcw_cursor #(
    parameter int COLUMNS = ttcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = ttcw_pkg::ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ttcw_pkg::CHAR_W-1:0]         char_code,
    input  ttcw_pkg::cursor_ctl_t               ctl,
    output ttcw_pkg::put_plan_t                 plan,
    output logic [$clog2(ROWS*COLUMNS)-1:0]     wr_addr,
    output logic [$clog2(ROWS*COLUMNS+1)-1:0]   pos
);
    import ttcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] base_reg, base_next;

    logic          is_cr, is_bs, is_lf, at_end, last_row, wrap, row_adv;
    logic [AW-1:0] base_put, addr_base;
    logic [CW-1:0] col_put, addr_col;
    logic [PW-1:0] addr_sum;

    always_comb
    begin
        is_cr    = (char_code == CHAR_CR);
        is_bs    = (char_code == CHAR_BS);
        is_lf    = (char_code == CHAR_LF);
        at_end   = (col_reg == CW'(COLUMNS));
        last_row = (row_reg == RW'(ROWS - 1));
        wrap     = is_lf || (at_end && !is_cr && !is_bs);
        row_adv  = wrap && !last_row;
        base_put = row_adv ? (base_reg + AW'(COLUMNS)) : base_reg;
        col_put  = wrap ? '0 : col_reg;

        addr_base = is_bs ? base_reg : base_put;
        addr_col  = is_bs ? (col_reg - CW'(1)) : col_put;
        addr_sum  = PW'(addr_base) + PW'(addr_col);
        wr_addr   = addr_sum[AW-1:0];

        plan.scroll  = wrap && last_row;
        plan.wr_en   = is_bs ? (col_reg != '0) : (!is_cr && !is_lf);
        plan.wr_data = is_bs ? CHAR_SPACE : char_code;

        pos = PW'(base_reg) + PW'(col_reg);
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (ctl.clear)
        begin
            col_next  = '0;
            row_next  = '0;
            base_next = '0;
        end
        else if (ctl.update)
        begin
            priority if (is_cr || is_lf)
            begin
                col_next = '0;
            end
            else if (is_bs)
            begin
                col_next = (col_reg != '0) ? (col_reg - CW'(1)) : col_reg;
            end
            else
            begin
                col_next = col_put + CW'(1);
            end
            if (row_adv)
            begin
                row_next  = row_reg + RW'(1);
                base_next = base_put;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

endmodule

// File: hdl/text_terminal_char_writer_core.sv
// text_terminal_char_writer_core: top level of the character cell screen engine
// depends on ttcw_pkg, ttcw_ram and ttcw_cursor
//
// A command word (cmd) is taken at a rising edge where start is high and busy
// is low. Each command gives one result word (result), shown for exactly one
// cycle with done high; the receiver cannot hold results off.
// Steps from the accepting edge to the done cycle:
//   put without scroll, read, unused code: the EXEC state, then the registered done
//   put that scrolls: EXEC, then a copy pass through the screen
//     ram, one cell a cycle, then a blanking pass over the bottom row, then the put
//   clear: EXEC, then a fill pass, one cell a cycle
// The screen ram has one write and one registered read port; scroll and clear
// are bound by that one cell per cycle.
// After reset the block runs a fill pass that writes
// spaces to every cell, with busy high; the cursor resets to the top left.
// Results never wait: done is high in a cycle where busy is low, so the next
// command may be accepted in that same cycle.
module text_terminal_char_writer_core #(
    parameter int COLUMNS = ttcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = ttcw_pkg::ROWS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  ttcw_pkg::cmd_word_t    cmd,
    output logic                   busy,
    output logic                   done,
    output ttcw_pkg::result_word_t result
);
    import ttcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = $clog2(CELLS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_MOVE = 5'b00100,
        S_FILL = 5'b01000,
        S_PUT  = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        MODE_INIT   = 3'b001,
        MODE_CLEAR  = 3'b010,
        MODE_SCROLL = 3'b100
    } fill_mode_t;

    state_t        state_reg, state_next;
    fill_mode_t    mode_reg, mode_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic          hit_reg, hit_next;
    cmd_word_t     cmd_reg;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [CHAR_W-1:0] ram_wdata, ram_rdata;

    cursor_ctl_t       cur_ctl;
    put_plan_t         plan;
    logic [AW-1:0]     cur_addr;
    logic [PW-1:0]     cur_pos;

    logic              idx_ok, cnt_last, move_rd;
    logic [AW:0]       move_sum;
    logic [AW+POS_W-1:0] idx_ext;
    logic [PW+POS_W-1:0] pos_ext;

    ttcw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ttcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (cmd_reg.char_code),
        .ctl       (cur_ctl),
        .plan      (plan),
        .wr_addr   (cur_addr),
        .pos       (cur_pos)
    );

    always_comb
    begin
        idx_ok   = ({21'b0, cmd_reg.cell_index} < 32'(CELLS));
        idx_ext  = {{AW{1'b0}}, cmd_reg.cell_index};
        cnt_last = (cnt_reg == AW'(CELLS - 1));
        move_rd  = (cnt_reg < AW'(CELLS - COLUMNS));
        move_sum = (AW + 1)'(cnt_reg) + (AW + 1)'(COLUMNS);

        state_next     = state_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        done_next      = 1'b0;
        hit_next       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cur_addr;
        ram_wdata      = plan.wr_data;
        ram_re         = 1'b0;
        ram_raddr      = idx_ext[AW-1:0];
        cur_ctl.update = 1'b0;
        cur_ctl.clear  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cmd_reg.func)
                    FUNC_PUT:
                    begin
                        if (plan.scroll)
                        begin
                            cnt_next   = '0;
                            state_next = S_MOVE;
                        end
                        else
                        begin
                            ram_we         = plan.wr_en;
                            cur_ctl.update = 1'b1;
                            done_next      = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        cnt_next   = '0;
                        mode_next  = MODE_CLEAR;
                        state_next = S_FILL;
                    end
                    FUNC_READ:
                    begin
                        ram_re     = idx_ok;
                        hit_next   = idx_ok;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    FUNC_NONE:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MOVE:
            begin
                ram_re    = move_rd;
                ram_raddr = move_sum[AW-1:0];
                ram_we    = (cnt_reg != '0);
                ram_waddr = cnt_reg - AW'(1);
                ram_wdata = ram_rdata;
                if (move_rd)
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
                else
                begin
                    mode_next  = MODE_SCROLL;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = CHAR_SPACE;
                if (cnt_last)
                begin
                    unique case (mode_reg)
                        MODE_INIT:
                        begin
                            state_next = S_IDLE;
                        end
                        MODE_CLEAR:
                        begin
                            cur_ctl.clear = 1'b1;
                            done_next     = 1'b1;
                            state_next    = S_IDLE;
                        end
                        MODE_SCROLL:
                        begin
                            state_next = S_PUT;
                        end
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_PUT:
            begin
                ram_we         = plan.wr_en;
                cur_ctl.update = 1'b1;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
            mode_reg  <= MODE_INIT;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
    end

    assign pos_ext = {{POS_W{1'b0}}, cur_pos};

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign result.cursor_pos = pos_ext[POS_W-1:0];
    assign result.cell_char  = hit_reg ? ram_rdata : '0;

endmodule

// File: hdl/ttcw_checker.sv
// ttcw_checker: port-level checks of the command and result handshake
// depends on ttcw_pkg; bound to text_terminal_char_writer_core below
module ttcw_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input ttcw_pkg::cmd_word_t    cmd,
    input logic                   busy,
    input logic                   done,
    input ttcw_pkg::result_word_t result
);
    import ttcw_pkg::*;

    // a result never shows while a command is still in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");

    // an accepted command always makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // results are single-cycle strobes
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for two cycles");

    // the screen is wiped after reset before any command is taken
    assert property (@(posedge clk) (rst_n && !$past(rst_n)) |-> (busy && !done))
        else $error("not busy right after reset");

    // an unused code answers with an empty cell field
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.func == FUNC_NONE)) |-> ##2 (done && (result.cell_char == '0)))
        else $error("unused code gave no empty result");

endmodule

bind text_terminal_char_writer_core ttcw_checker u_ttcw_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: tb/sv/text_terminal_char_writer_core_tb.sv
// text_terminal_char_writer_core_tb: self-checking testbench for the character cell screen engine
// depends on ttcw_pkg and text_terminal_char_writer_core; directed table, then random
// line-oriented traffic, each result checked against a table value or the bench screen predictor
module text_terminal_char_writer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ttcw_pkg::*;

    localparam int COLUMNS    = COLUMNS_DEF;
    localparam int ROWS       = ROWS_DEF;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int STALL_MAX  = 10000;
    localparam int GAP_MAX    = 30;
    localparam int DRAIN_WAIT = 8;
    localparam int DIR_ROWS   = 21;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  cell_index;
        logic              typed;
        logic [POS_W-1:0]  cursor_pos;
        logic [CHAR_W-1:0] cell_char;
    } dir_row_t;

    // typed rows carry a known result; the others go through the predictor
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{FUNC_READ,  8'h00,   11'd0,    1'b1, 11'd0,  CHAR_SPACE},
        '{FUNC_READ,  8'h00,   11'd1999, 1'b1, 11'd0,  CHAR_SPACE},
        '{FUNC_READ,  8'hFF,   11'd2000, 1'b1, 11'd0,  8'h00},
        '{FUNC_READ,  8'h00,   11'd2047, 1'b1, 11'd0,  8'h00},
        '{FUNC_NONE,  8'hFF,   11'd2047, 1'b1, 11'd0,  8'h00},
        '{FUNC_PUT,   CHAR_BS, 11'd0,    1'b1, 11'd0,  8'h00},
        '{FUNC_PUT,   8'hFF,   11'd2047, 1'b1, 11'd1,  8'h00},
        '{FUNC_PUT,   8'h00,   11'd0,    1'b1, 11'd2,  8'h00},
        '{FUNC_READ,  8'h00,   11'd0,    1'b1, 11'd2,  8'hFF},
        '{FUNC_READ,  8'h00,   11'd1,    1'b1, 11'd2,  8'h00},
        '{FUNC_PUT,   CHAR_BS, 11'd0,    1'b1, 11'd1,  8'h00},
        '{FUNC_READ,  8'h00,   11'd1,    1'b1, 11'd1,  CHAR_SPACE},
        '{FUNC_PUT,   CHAR_CR, 11'd0,    1'b1, 11'd0,  8'h00},
        '{FUNC_PUT,   CHAR_LF, 11'd0,    1'b1, 11'd80, 8'h00},
        '{FUNC_PUT,   8'h41,   11'd0,    1'b1, 11'd81, 8'h00},
        '{FUNC_PUT,   8'h7F,   11'd1024, 1'b0, 11'd0,  8'h00},
        '{FUNC_READ,  8'h00,   11'd81,   1'b0, 11'd0,  8'h00},
        '{FUNC_READ,  8'h00,   11'd82,   1'b0, 11'd0,  8'h00},
        '{FUNC_CLEAR, 8'hFF,   11'd2047, 1'b1, 11'd0,  8'h00},
        '{FUNC_READ,  8'h00,   11'd80,   1'b1, 11'd0,  CHAR_SPACE},
        '{FUNC_PUT,   CHAR_CR, 11'd0,    1'b1, 11'd0,  8'h00}
    };

    logic         clk   = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    cmd_word_t    cmd   = '0;
    logic         busy;
    logic         done;
    result_word_t res_word;

    result_word_t expected_results[$];

    logic [CHAR_W-1:0] screen_copy [CELLS];
    int unsigned       cur_col;
    int unsigned       cur_row;

    int send_idle_pct = 0;
    int n_cmds        = 0;
    int n_results     = 0;
    int n_errors      = 0;
    int n_wraps       = 0;
    int n_scrolls     = 0;
    int n_clears      = 0;
    int stall_cycles  = 0;

    text_terminal_char_writer_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (res_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void screen_blank();
        for (int i = 0; i < CELLS; i++)
        begin
            screen_copy[i] = CHAR_SPACE;
        end
        cur_col = 0;
        cur_row = 0;
    endfunction

    function automatic void screen_scroll();
        for (int i = 0; i < CELLS - COLUMNS; i++)
        begin
            screen_copy[i] = screen_copy[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
        begin
            screen_copy[i] = CHAR_SPACE;
        end
        cur_row = ROWS - 1;
        n_scrolls++;
    endfunction

    function automatic void screen_put(logic [CHAR_W-1:0] ch);
        if (ch == CHAR_CR)
        begin
            cur_col = 0;
        end
        else if (ch == CHAR_BS)
        begin
            if (cur_col > 0)
            begin
                cur_col--;
                if (cur_col < COLUMNS)
                begin
                    screen_copy[cur_row * COLUMNS + cur_col] = CHAR_SPACE;
                end
            end
        end
        else
        begin
            if (ch == CHAR_LF)
            begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_col >= COLUMNS)
            begin
                cur_col = 0;
                cur_row++;
                n_wraps++;
            end
            if (cur_row >= ROWS)
            begin
                screen_scroll();
            end
            if (ch != CHAR_LF)
            begin
                screen_copy[cur_row * COLUMNS + cur_col] = ch;
                cur_col++;
            end
        end
    endfunction

    function automatic result_word_t screen_predict(cmd_word_t w);
        result_word_t r;
        int unsigned  pos;
        r = '0;
        case (w.func)
            FUNC_PUT:   screen_put(w.char_code);
            FUNC_CLEAR:
            begin
                screen_blank();
                n_clears++;
            end
            FUNC_READ:
            begin
                if (w.cell_index < CELLS)
                begin
                    r.cell_char = screen_copy[w.cell_index];
                end
            end
            default: ;
        endcase
        pos = cur_row * COLUMNS + cur_col;
        r.cursor_pos = pos[POS_W-1:0];
        return r;
    endfunction

    function automatic cmd_word_t put_word(logic [CHAR_W-1:0] ch);
        cmd_word_t w;
        w.func       = FUNC_PUT;
        w.char_code  = ch;
        w.cell_index = POS_W'($urandom_range(2047));
        return w;
    endfunction

    function automatic cmd_word_t read_word(int unsigned idx);
        cmd_word_t w;
        w.func       = FUNC_READ;
        w.char_code  = CHAR_W'($urandom_range(255));
        w.cell_index = POS_W'(idx);
        return w;
    endfunction

    function automatic logic [CHAR_W-1:0] text_char();
        if ($urandom_range(99) < 25)
        begin
            return CHAR_W'($urandom_range(255));
        end
        return CHAR_W'($urandom_range(8'h7E, 8'h20));
    endfunction

    task automatic issue_cmd(input cmd_word_t w, input logic typed, input result_word_t known);
        int           gap;
        result_word_t pred;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        do @(posedge clk); while (busy);
        pred = screen_predict(w);
        expected_results.push_back(typed ? known : pred);
        n_cmds++;
    endtask

    task automatic issue(input cmd_word_t w);
        issue_cmd(w, 1'b0, '0);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic type_line();
        int len;
        if ($urandom_range(99) < 8)
        begin
            len = $urandom_range(COLUMNS + 1, COLUMNS - 2);
        end
        else
        begin
            len = $urandom_range(12);
        end
        for (int k = 0; k < len; k++)
        begin
            issue(put_word(text_char()));
        end
        if ($urandom_range(9) != 0)
        begin
            issue(put_word(CHAR_LF));
        end
        else
        begin
            issue(put_word(CHAR_CR));
        end
    endtask

    task automatic edit_burst();
        int n;
        n = $urandom_range(6);
        for (int k = 0; k < n; k++)
        begin
            issue(put_word(text_char()));
        end
        n = $urandom_range(8, 1);
        for (int k = 0; k < n; k++)
        begin
            issue(put_word(CHAR_BS));
        end
        issue(read_word(cur_row * COLUMNS + $urandom_range(COLUMNS - 1)));
        if ($urandom_range(3) == 0)
        begin
            issue(put_word(CHAR_CR));
        end
    endtask

    task automatic read_burst();
        int n;
        int sel;
        n = $urandom_range(4, 1);
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(9);
            if (sel < 6)
            begin
                issue(read_word(cur_row * COLUMNS + $urandom_range(COLUMNS - 1)));
            end
            else if (sel < 8)
            begin
                issue(read_word($urandom_range(CELLS - 1)));
            end
            else
            begin
                issue(read_word($urandom_range(2047)));
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int n_items);
        int target;
        int pick;
        cmd_word_t w;
        send_idle_pct = idle_pct;
        target = n_cmds + n_items;
        while (n_cmds < target)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                type_line();
            end
            else if (pick < 68)
            begin
                repeat ($urandom_range(6, 1)) issue(put_word(CHAR_LF));
            end
            else if (pick < 78)
            begin
                edit_burst();
            end
            else if (pick < 92)
            begin
                read_burst();
            end
            else
            begin
                w.func       = FUNC_W'($urandom_range(3));
                w.char_code  = CHAR_W'($urandom_range(255));
                w.cell_index = POS_W'($urandom_range(2047));
                issue(w);
            end
        end
        drain_results();
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_word_t exp_word;
        if (rst_n && done)
        begin
            n_results++;
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected: cursor_pos %0d cell_char %02h",
                       res_word.cursor_pos, res_word.cell_char);
                n_errors++;
            end
            else
            begin
                exp_word = expected_results.pop_front();
                if (res_word.cursor_pos !== exp_word.cursor_pos)
                begin
                    $error("cursor_pos: expected %0d, actual %0d",
                           exp_word.cursor_pos, res_word.cursor_pos);
                    n_errors++;
                end
                if (res_word.cell_char !== exp_word.cell_char)
                begin
                    $error("cell_char: expected %02h, actual %02h",
                           exp_word.cell_char, res_word.cell_char);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((start && !busy && rst_n) || (done && rst_n))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_MAX)
        begin
            $display("watchdog: no word moved for %0d cycles", STALL_MAX);
            $display("** text_terminal_char_writer_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        cmd_word_t    w;
        result_word_t known;
        screen_blank();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 0;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            w.func           = DIR_TAB[i].func;
            w.char_code      = DIR_TAB[i].char_code;
            w.cell_index     = DIR_TAB[i].cell_index;
            known.cursor_pos = DIR_TAB[i].cursor_pos;
            known.cell_char  = DIR_TAB[i].cell_char;
            issue_cmd(w, DIR_TAB[i].typed, known);
        end
        drain_results();

        run_phase(0, 240);
        run_phase(82, 230);
        run_phase(8, 230);

        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d command words sent, %0d result words checked", n_cmds, n_results);
        $display("covered %0d line wraps, %0d scrolls, %0d clears", n_wraps, n_scrolls, n_clears);
        if (n_errors == 0 && expected_results.size() == 0)
        begin
            $display("** text_terminal_char_writer_core: PASSED **");
        end
        else
        begin
            $display("** text_terminal_char_writer_core: FAILED **");
        end
        $finish;
    end

endmodule
